>>> rtl/pcpi_pkg.sv
// Shared types, codes and constants of the per-cell PI fuel correction block.
`timescale 1ns / 1ps
`default_nettype none
package pcpi_pkg;

	typedef enum logic [1:0] {
		FN_SAMPLE = 2'd0,
		FN_CLEAR  = 2'd1,
		FN_READ   = 2'd2,
		FN_TARGET = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		CFG_FILTER = 3'd0,
		CFG_GAIN_P = 3'd1,
		CFG_GAIN_I = 3'd2,
		CFG_WARM   = 3'd3,
		CFG_CRANK  = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_SWEEP_END,
		ST_READ,
		ST_MUL_AVG,
		ST_MUL_P,
		ST_MUL_I,
		ST_DIV_INIT,
		ST_DIV,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [25:0]        avg;
		logic signed [24:0] integ;
		logic signed [40:0] corr;
		logic [23:0]        cnt;
	} cell_rec_t;

	typedef struct packed {
		logic done;
		logic rem_nz;
	} div_stat_t;

	localparam int unsigned DIV_DIGITS = 4;
	localparam logic [22:0] DIV_RECIP = 23'd4294968;
	localparam logic [21:0] DIVISOR = 22'd1000;
	localparam logic signed [24:0] INTEG_LIMIT = 25'sd10000000;
	localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

endpackage
`default_nettype wire

>>> rtl/pcpi_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module pcpi_mul (
	input  wire logic               clk,
	input  wire logic signed [24:0] a,
	input  wire logic signed [26:0] b,
	output logic signed [51:0]      p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule
`default_nettype wire

>>> rtl/pcpi_div.sv
// Divider of an unsigned magnitude by the constant 1000, one 12-bit digit at a time.
`timescale 1ns / 1ps
`default_nettype none
module pcpi_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [47:0]  num,
	output pcpi_pkg::div_stat_t stat,
	output logic [47:0]       quo
);
	import pcpi_pkg::*;

	logic        busy_q;
	logic        phase_q;
	logic        done_q;
	logic [1:0]  cnt_q;
	logic [47:0] sh_q;
	logic [9:0]  rem_q;
	logic [21:0] x;
	logic [21:0] x_q;
	logic [44:0] prod;
	logic [11:0] qd_q;
	logic [21:0] r;

	// The digit quotient is floor(x * ceil(2^32 / 1000) / 2^32), exact for x below 2^22.
	assign x    = {rem_q, sh_q[47:36]};
	assign prod = 45'(x) * 45'(DIV_RECIP);
	assign r    = x_q - 22'(qd_q) * DIVISOR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= '0;
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'(DIV_DIGITS - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				x_q  <= x;
				qd_q <= prod[43:32];
			end else begin
				rem_q <= r[9:0];
				sh_q  <= {sh_q[35:0], qd_q};
			end
		end
	end

	assign stat.done   = done_q;
	assign stat.rem_nz = (rem_q != 10'd0);
	assign quo         = sh_q;
endmodule
`default_nettype wire

>>> rtl/per_cell_pi_afr_correction.sv
// Top level of the per-cell PI fuel correction block.
// The block takes one item at a time. A sample that is used for control goes through a memory
// read, three passes through one shared multiplier, and a division of the integral term by
// 1000 in four 12-bit digits, each found by reciprocal multiplication. Reads, target writes and
// unused samples skip the multiplier and divider. A clear item sweeps every cell, one per cycle;
// the same sweep runs after reset, during which no item is accepted. The result waits in an
// output register, and a finished result that is not yet taken holds back only the next result.
`timescale 1ns / 1ps
`default_nettype none
module per_cell_pi_afr_correction #(
	parameter int LOAD_CELLS  = 16,
	parameter int SPEED_CELLS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic [3:0]         load_cell,
	input  wire logic [3:0]         speed_cell,
	input  wire logic [9:0]         lambda_mv,
	input  wire logic [13:0]        engine_rpm,
	input  wire logic signed [8:0]  engine_temp,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    active,
	output logic signed [40:0]      correction,
	output logic [25:0]             average_q16,
	output logic [23:0]             sample_count,
	output logic [7:0]              cell_number,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_wdata
);
	import pcpi_pkg::*;

	localparam int CELLS = LOAD_CELLS * SPEED_CELLS;
	localparam int AW    = $clog2(CELLS);

	state_t state_q, state_nx;

	logic [15:0]        filt_q;
	logic signed [23:0] gp_q;
	logic signed [23:0] gi_q;
	logic signed [8:0]  warm_q;
	logic [13:0]        crank_q;

	logic [1:0]  func_q;
	logic [9:0]  mv_q;
	logic        rng_q;
	logic        act_q;
	logic [AW-1:0] addr_q;
	logic [7:0]  celln_q;
	logic        rst_pass_q;
	logic [AW-1:0] rp_q;
	logic [AW-1:0] sw_ptr_q;
	logic [AW-1:0] sw_addr_s1;

	cell_rec_t cell_mem [CELLS];
	logic [9:0] target_mem [CELLS];
	cell_rec_t rd_q;
	logic [9:0] tgt_q;

	logic [31:0]   cell_full;
	logic          in_rng;
	logic          accept;

	logic          tgt_we;
	logic          tgt_re;
	logic [AW-1:0] tgt_ra;
	logic          mem_re;
	logic [AW-1:0] mem_ra;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	cell_rec_t     mem_wd;
	logic          out_load;
	logic          div_start;
	logic signed [24:0] mul_a;
	logic signed [26:0] mul_b;
	logic signed [51:0] prod_q;

	logic signed [26:0] d;
	logic signed [10:0] e;
	logic signed [25:0] integ_sum;
	logic               integ_ok;
	logic signed [36:0] avg_sum;
	logic signed [51:0] prod_neg;
	logic [47:0]        mag;

	logic [25:0]        avg_new_q;
	logic signed [24:0] integ_new_q;
	logic [23:0]        cnt_new_q;
	logic signed [40:0] pe_q;
	logic signed [40:0] corr_q;
	logic               neg_q;

	div_stat_t   dstat;
	logic [47:0] quo;
	logic [40:0] qa;
	logic signed [40:0] fq;
	logic signed [40:0] corr_w;

	logic               res_act;
	logic signed [40:0] res_corr;
	logic [25:0]        res_avg;
	logic [23:0]        res_cnt;
	logic [7:0]         res_cell;

	logic out_valid_q;

	assign cell_full = 32'(load_cell) * 32'(SPEED_CELLS) + 32'(speed_cell);
	assign in_rng    = (32'(load_cell) < 32'(LOAD_CELLS)) && (32'(speed_cell) < 32'(SPEED_CELLS));
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q  <= 16'd66;
			gp_q    <= '0;
			gi_q    <= '0;
			warm_q  <= 9'sd60;
			crank_q <= 14'd400;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FILTER: filt_q  <= cfg_wdata[15:0];
				CFG_GAIN_P: gp_q    <= $signed(cfg_wdata);
				CFG_GAIN_I: gi_q    <= $signed(cfg_wdata);
				CFG_WARM:   warm_q  <= $signed(cfg_wdata[8:0]);
				CFG_CRANK:  crank_q <= cfg_wdata[13:0];
				default: ;
			endcase
		end
	end

	pcpi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	pcpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag),
		.stat   (dstat),
		.quo    (quo)
	);

	assign d = $signed({1'b0, mv_q, 16'b0}) - $signed({1'b0, rd_q.avg});
	assign e = $signed({1'b0, tgt_q}) - $signed({1'b0, mv_q});
	assign integ_sum = 26'(rd_q.integ) + 26'(e);
	assign integ_ok  = (rd_q.integ < INTEG_LIMIT) && (rd_q.integ > -INTEG_LIMIT);
	assign avg_sum   = 37'($signed({11'b0, rd_q.avg})) + 37'(prod_q[51:16]);
	assign prod_neg  = -prod_q;
	assign mag       = prod_q[51] ? prod_neg[47:0] : prod_q[47:0];
	assign qa        = {3'b0, quo[37:0]} + {40'b0, neg_q & dstat.rem_nz};
	assign fq        = neg_q ? -$signed(qa) : $signed(qa);
	assign corr_w    = pe_q + fq;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (func == FN_CLEAR) state_nx = ST_SWEEP;
					else if (func == FN_READ) state_nx = ST_READ;
					else if (!in_rng || func == FN_TARGET) state_nx = ST_DONE;
					else state_nx = ST_READ;
				end
			end
			ST_SWEEP: begin
				if (sw_ptr_q == AW'(CELLS - 1)) state_nx = ST_SWEEP_END;
			end
			ST_SWEEP_END: state_nx = rst_pass_q ? ST_IDLE : ST_DONE;
			ST_READ: state_nx = (func_q == FN_SAMPLE && act_q) ? ST_MUL_AVG : ST_DONE;
			ST_MUL_AVG: state_nx = ST_MUL_P;
			ST_MUL_P: state_nx = ST_MUL_I;
			ST_MUL_I: state_nx = ST_DIV_INIT;
			ST_DIV_INIT: state_nx = ST_DIV;
			ST_DIV: begin
				if (dstat.done) state_nx = ST_WRITE;
			end
			ST_WRITE: state_nx = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		tgt_we    = 1'b0;
		tgt_re    = 1'b0;
		tgt_ra    = addr_q;
		mem_re    = 1'b0;
		mem_ra    = addr_q;
		mem_we    = 1'b0;
		mem_wa    = addr_q;
		mem_wd    = '{avg: avg_new_q, integ: integ_new_q, corr: corr_w, cnt: cnt_new_q};
		out_load  = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: tgt_we = accept && func == FN_TARGET && in_rng;
			ST_SWEEP: begin
				tgt_re = 1'b1;
				tgt_ra = sw_ptr_q;
				mem_we = (sw_ptr_q != '0);
				mem_wa = sw_addr_s1;
				mem_wd = '{avg: {tgt_q, 16'b0}, integ: '0, corr: '0, cnt: '0};
			end
			ST_SWEEP_END: begin
				mem_we = 1'b1;
				mem_wa = sw_addr_s1;
				mem_wd = '{avg: {tgt_q, 16'b0}, integ: '0, corr: '0, cnt: '0};
			end
			ST_READ: begin
				tgt_re = 1'b1;
				mem_re = 1'b1;
				mem_ra = (func_q == FN_READ) ? rp_q : addr_q;
			end
			ST_MUL_AVG: begin
				mul_a = $signed({9'b0, filt_q});
				mul_b = d;
			end
			ST_MUL_P: begin
				mul_a = 25'(gp_q);
				mul_b = 27'(e);
			end
			ST_MUL_I: begin
				mul_a = 25'(gi_q);
				mul_b = 27'(integ_new_q);
			end
			ST_DIV_INIT: div_start = 1'b1;
			ST_WRITE: mem_we = 1'b1;
			ST_DONE: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tgt_we) target_mem[AW'(cell_full)] <= lambda_mv;
		if (tgt_re) tgt_q <= target_mem[tgt_ra];
		if (mem_we) cell_mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= cell_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			rst_pass_q <= 1'b1;
			sw_ptr_q   <= '0;
			rp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_SWEEP_END) rst_pass_q <= 1'b0;
			if (state_q == ST_SWEEP) sw_ptr_q <= sw_ptr_q + AW'(1);
			else sw_ptr_q <= '0;
			if (out_load && func_q == FN_READ)
				rp_q <= (rp_q == AW'(CELLS - 1)) ? '0 : rp_q + AW'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		sw_addr_s1 <= sw_ptr_q;
		if (accept) begin
			func_q  <= func;
			mv_q    <= lambda_mv;
			rng_q   <= in_rng;
			act_q   <= (engine_temp > warm_q) && (engine_rpm > crank_q);
			addr_q  <= AW'(cell_full);
			celln_q <= cell_full[7:0];
		end
		if (state_q == ST_MUL_AVG) begin
			integ_new_q <= integ_ok ? integ_sum[24:0] : rd_q.integ;
			cnt_new_q   <= (rd_q.cnt == COUNT_MAX) ? COUNT_MAX : rd_q.cnt + 24'd1;
		end
		if (state_q == ST_MUL_P) avg_new_q <= avg_sum[25:0];
		if (state_q == ST_MUL_I) pe_q <= 41'(prod_q);
		if (state_q == ST_DIV_INIT) neg_q <= prod_q[51];
		if (state_q == ST_WRITE) corr_q <= corr_w;
		if (out_load) begin
			active       <= res_act;
			correction   <= res_corr;
			average_q16  <= res_avg;
			sample_count <= res_cnt;
			cell_number  <= res_cell;
		end
	end

	always_comb begin
		res_act  = 1'b0;
		res_corr = '0;
		res_avg  = '0;
		res_cnt  = '0;
		res_cell = celln_q;
		case (func_q)
			FN_CLEAR: res_cell = '0;
			FN_READ: begin
				res_corr = rd_q.corr;
				res_avg  = rd_q.avg;
				res_cnt  = rd_q.cnt;
				res_cell = 8'(rp_q);
			end
			FN_SAMPLE: begin
				if (rng_q && act_q) begin
					res_act  = 1'b1;
					res_corr = corr_q;
					res_avg  = avg_new_q;
					res_cnt  = cnt_new_q;
				end else if (rng_q) begin
					res_corr = rd_q.corr;
					res_avg  = rd_q.avg;
					res_cnt  = rd_q.cnt;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire
